// File: src/assert_macros.svh
// Assertion macros used by the sorted time slot table RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge of clk.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/sts_pkg.sv
// Package for the sorted time slot table: field widths, codes and shared types.
// Used by sts_cell and sorted_time_slot_table_unit; depends on nothing else.
`default_nettype none

package sts_pkg;

    // Field widths of the ports.
    localparam int OP_W     = 2;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int KEY_W    = HOUR_W + MINUTE_W;

    // Time range limits and register reset value.
    localparam logic [HOUR_W-1:0]   HOURS_PER_DAY    = 5'd24;
    localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR = 6'd60;
    localparam logic [COUNT_W-1:0]  CAPACITY_RESET   = 7'd50;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADTIME  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADINDEX = 3'd4;

    // Values broadcast from the control to every cell of the row.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
    } bcast_t;

endpackage

`default_nettype wire

// File: src/sts_cell.sv
// One cell of the sorted key row: holds one key, compares it against the
// broadcast key and index, and shifts toward the right on insert. Uses sts_pkg.
`default_nettype none

module sts_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic                     clk,
    input  wire sts_pkg::bcast_t          bcast,
    input  wire logic                     write_en,
    input  wire logic [sts_pkg::KEY_W-1:0] left_key,
    input  wire logic                     left_after,
    output logic      [sts_pkg::KEY_W-1:0] key_out,
    output logic                          after_out,
    output logic                          present,
    output logic      [sts_pkg::KEY_W-1:0] read_key
);

    logic [sts_pkg::KEY_W-1:0] key_reg;
    logic [sts_pkg::KEY_W-1:0] key_next;
    logic                      present_reg;
    logic                      present_next;
    logic [sts_pkg::KEY_W-1:0] read_reg;
    logic [sts_pkg::KEY_W-1:0] read_next;
    logic                      occupied;
    logic                      at_count;

    // Position of this cell relative to the fill level.
    assign occupied = CELL_IDX < 32'(bcast.count);
    assign at_count = CELL_IDX == 32'(bcast.count);

    // This cell sits at or after the insertion point: its key is larger than the
    // new one, or it is the first empty cell.
    assign after_out = (occupied && (key_reg > bcast.key)) || at_count;
    assign key_out   = key_reg;

    // On insert, cells past the insertion point take their left neighbor's key,
    // and the cell at the insertion point takes the new key.
    always_comb
    begin
        key_next = key_reg;
        if (write_en)
        begin
            priority if (left_after)
            begin
                key_next = left_key;
            end
            else if (after_out)
            begin
                key_next = bcast.key;
            end
            else
            begin
                key_next = key_reg;
            end
        end
    end

    // Match flag and index-selected key, registered for the row reduction.
    assign present_next = occupied && (key_reg == bcast.key);
    assign read_next    = (CELL_IDX == 32'(bcast.index)) ? key_reg : '0;

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        present_reg <= present_next;
        read_reg    <= read_next;
    end

    assign present  = present_reg;
    assign read_key = read_reg;

endmodule

`default_nettype wire

// File: src/sorted_time_slot_table_unit.sv
// Sorted time slot table: a row of MAX_ENTRIES cells holding time keys in order.
// A result passes through the item registers, the cell flag registers and the output register.
// A new item is taken only in S_IDLE, once the broadcast, compare and
// reduce/commit sequence over the cell row for the previous item is done.
// Reset: control, count (0) and capacity (50) are cleared; cell keys are not.
// A new item is taken while the previous result still waits at the output.
`default_nettype none
`include "assert_macros.svh"

module sorted_time_slot_table_unit #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write
    input  wire logic                          cfg_we,
    input  wire logic [sts_pkg::COUNT_W-1:0]   cfg_wdata,
    // Input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sts_pkg::OP_W-1:0]      op,
    input  wire logic [sts_pkg::HOUR_W-1:0]    slot_hour,
    input  wire logic [sts_pkg::MINUTE_W-1:0]  slot_minute,
    input  wire logic [sts_pkg::INDEX_W-1:0]   entry_index,
    // Output channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [sts_pkg::STATUS_W-1:0]  status,
    output logic      [sts_pkg::COUNT_W-1:0]   entry_count,
    output logic      [sts_pkg::HOUR_W-1:0]    read_hour,
    output logic      [sts_pkg::MINUTE_W-1:0]  read_minute
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic [sts_pkg::COUNT_W-1:0]       capacity_reg;
    logic [sts_pkg::COUNT_W-1:0]       count_reg;
    logic [sts_pkg::COUNT_W-1:0]       count_next;
    logic [sts_pkg::OP_W-1:0]          op_reg;
    logic [sts_pkg::KEY_W-1:0]         key_reg;
    logic [sts_pkg::INDEX_W-1:0]       index_reg;

    logic                              out_valid_reg;
    logic [sts_pkg::STATUS_W-1:0]      status_reg;
    logic [sts_pkg::STATUS_W-1:0]      status_next;
    logic [sts_pkg::COUNT_W-1:0]       entry_count_reg;
    logic [sts_pkg::HOUR_W-1:0]        read_hour_reg;
    logic [sts_pkg::HOUR_W-1:0]        read_hour_next;
    logic [sts_pkg::MINUTE_W-1:0]      read_minute_reg;
    logic [sts_pkg::MINUTE_W-1:0]      read_minute_next;

    sts_pkg::bcast_t                   bcast;
    logic [sts_pkg::KEY_W-1:0]         cell_key     [MAX_ENTRIES];
    logic                              cell_after   [MAX_ENTRIES];
    logic                              cell_present [MAX_ENTRIES];
    logic [sts_pkg::KEY_W-1:0]         cell_read    [MAX_ENTRIES];

    logic                              in_fire;
    logic                              out_free;
    logic                              commit;
    logic                              do_insert;
    logic                              table_full;
    logic                              bad_time;
    logic                              index_ok;
    logic                              present_any;
    logic [sts_pkg::KEY_W-1:0]         read_any;
    logic [sts_pkg::HOUR_W-1:0]        key_hour;
    logic [sts_pkg::MINUTE_W-1:0]      key_minute;

    // Handshake conditions.
    assign in_ready = state_reg == S_IDLE;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign commit   = (state_reg == S_DONE) && out_free;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= sts_pkg::CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    // Sequencer: broadcast, compare in the cells, then reduce and commit.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Item registers, loaded on an input transfer.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= op;
            key_reg   <= {slot_hour, slot_minute};
            index_reg <= entry_index;
        end
    end

    assign bcast.key   = key_reg;
    assign bcast.index = index_reg;
    assign bcast.count = count_reg;

    // Row of cells; each takes its left neighbor's key and insertion flag.
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [sts_pkg::KEY_W-1:0] left_key;
        logic                      left_after;
        if (i == 0)
        begin : g_first
            assign left_key   = '0;
            assign left_after = 1'b0;
        end
        else
        begin : g_rest
            assign left_key   = cell_key[i-1];
            assign left_after = cell_after[i-1];
        end

        sts_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk        (clk),
            .bcast      (bcast),
            .write_en   (do_insert),
            .left_key   (left_key),
            .left_after (left_after),
            .key_out    (cell_key[i]),
            .after_out  (cell_after[i]),
            .present    (cell_present[i]),
            .read_key   (cell_read[i])
        );
    end

    // Combine the registered cell flags; unselected cells drive zero keys.
    always_comb
    begin
        present_any = 1'b0;
        read_any    = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            present_any = present_any | cell_present[i];
            read_any    = read_any | cell_read[i];
        end
    end

    // Operation checks.
    assign key_hour   = key_reg[sts_pkg::KEY_W-1:sts_pkg::MINUTE_W];
    assign key_minute = key_reg[sts_pkg::MINUTE_W-1:0];
    assign bad_time   = (key_hour >= sts_pkg::HOURS_PER_DAY)
                     || (key_minute >= sts_pkg::MINUTES_PER_HOUR);
    assign table_full = (count_reg >= capacity_reg) || (32'(count_reg) >= MAX_ENTRIES);
    assign index_ok   = (32'(index_reg) < 32'(count_reg)) && (32'(index_reg) < MAX_ENTRIES);
    assign do_insert  = commit && (op_reg == sts_pkg::OP_INSERT) && !table_full && !bad_time;
    assign count_next = do_insert ? count_reg + 1'b1 : count_reg;

    // Result of the current operation.
    always_comb
    begin
        status_next      = sts_pkg::ST_OK;
        read_hour_next   = '0;
        read_minute_next = '0;
        unique case (op_reg)
            sts_pkg::OP_CHECK:
            begin
                priority if (table_full)
                begin
                    status_next = sts_pkg::ST_FULL;
                end
                else if (bad_time)
                begin
                    status_next = sts_pkg::ST_BADTIME;
                end
                else if (present_any)
                begin
                    status_next = sts_pkg::ST_TAKEN;
                end
                else
                begin
                    status_next = sts_pkg::ST_OK;
                end
            end
            sts_pkg::OP_INSERT:
            begin
                priority if (table_full)
                begin
                    status_next = sts_pkg::ST_FULL;
                end
                else if (bad_time)
                begin
                    status_next = sts_pkg::ST_BADTIME;
                end
                else
                begin
                    status_next = sts_pkg::ST_OK;
                end
            end
            sts_pkg::OP_READ:
            begin
                if (index_ok)
                begin
                    read_hour_next   = read_any[sts_pkg::KEY_W-1:sts_pkg::MINUTE_W];
                    read_minute_next = read_any[sts_pkg::MINUTE_W-1:0];
                end
                else
                begin
                    status_next = sts_pkg::ST_BADINDEX;
                end
            end
            default:
            begin
                status_next = sts_pkg::ST_OK;
            end
        endcase
    end

    // Output register; a result waits here until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg      <= status_next;
            entry_count_reg <= count_next;
            read_hour_reg   <= read_hour_next;
            read_minute_reg <= read_minute_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign read_hour   = read_hour_reg;
    assign read_minute = read_minute_reg;

    // The count only moves on the commit of an accepted insert.
    `ASSERT_CLK(a_count_on_insert, (count_reg != $past(count_reg)) |-> $past(do_insert), "count changed without an insert")
    // A new result is loaded only from the final step of the sequence.
    `ASSERT_CLK(a_out_from_done, $rose(out_valid_reg) |-> $past(state_reg == S_DONE), "result appeared outside the commit step")
    // The first two stored keys stay in non-descending order.
    `ASSERT_IMPLIES(a_sorted_head, (count_reg >= 7'd2) && (state_reg == S_IDLE), cell_key[0] <= cell_key[1], "stored keys out of order")

endmodule

`default_nettype wire

// File: tb/sorted_time_slot_table_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted time slot table: watches both channels and the capacity port.
// Predicts each result from its own copy of the table; depends on sts_pkg.

module slot_table_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sts_pkg::COUNT_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [sts_pkg::OP_W-1:0]      op,
    input  logic [sts_pkg::HOUR_W-1:0]    slot_hour,
    input  logic [sts_pkg::MINUTE_W-1:0]  slot_minute,
    input  logic [sts_pkg::INDEX_W-1:0]   entry_index,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [sts_pkg::STATUS_W-1:0]  status,
    input  logic [sts_pkg::COUNT_W-1:0]   entry_count,
    input  logic [sts_pkg::HOUR_W-1:0]    read_hour,
    input  logic [sts_pkg::MINUTE_W-1:0]  read_minute,
    output int                            fail_count,
    output int                            pending_count,
    output int                            checked_count
);
    import sts_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
        logic [HOUR_W-1:0]   read_hour;
        logic [MINUTE_W-1:0] read_minute;
    } slot_reply_t;

    // Shadow copy of the table, its fill level and the capacity register.
    logic [KEY_W-1:0]   shadow_keys [TABLE_DEPTH];
    int                 shadow_count = 0;
    logic [COUNT_W-1:0] shadow_capacity = CAPACITY_RESET;
    slot_reply_t        expected_replies [$];

    // Applies one request to the shadow table and returns the reply it should produce.
    function automatic slot_reply_t predict_reply(
        input logic [OP_W-1:0]     req_op,
        input logic [HOUR_W-1:0]   req_hour,
        input logic [MINUTE_W-1:0] req_minute,
        input logic [INDEX_W-1:0]  req_index
    );
        slot_reply_t      reply;
        logic [KEY_W-1:0] key;
        int               limit;
        int               pos;
        bit               is_full;
        bit               bad_time;
        bit               present;
        reply = '0;
        key = {req_hour, req_minute};
        limit = (int'(shadow_capacity) < TABLE_DEPTH) ? int'(shadow_capacity) : TABLE_DEPTH;
        is_full = (shadow_count >= limit);
        bad_time = (req_hour >= HOURS_PER_DAY) || (req_minute >= MINUTES_PER_HOUR);
        present = 1'b0;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_keys[i] == key)
                present = 1'b1;
        end
        case (req_op)
            OP_CHECK:
            begin
                if (is_full)
                    reply.status = ST_FULL;
                else if (bad_time)
                    reply.status = ST_BADTIME;
                else if (present)
                    reply.status = ST_TAKEN;
            end
            OP_INSERT:
            begin
                if (is_full)
                    reply.status = ST_FULL;
                else if (bad_time)
                    reply.status = ST_BADTIME;
                else
                begin
                    // The new key goes after every entry that is not greater.
                    pos = 0;
                    while (pos < shadow_count && shadow_keys[pos] <= key)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_keys[i] = shadow_keys[i - 1];
                    shadow_keys[pos] = key;
                    shadow_count++;
                end
            end
            OP_READ:
            begin
                if (int'(req_index) >= shadow_count)
                    reply.status = ST_BADINDEX;
                else
                begin
                    reply.read_hour = shadow_keys[req_index][KEY_W-1:MINUTE_W];
                    reply.read_minute = shadow_keys[req_index][MINUTE_W-1:0];
                end
            end
            default:
            begin
                // The spare operation code does nothing and answers ok.
            end
        endcase
        reply.entry_count = shadow_count[COUNT_W-1:0];
        return reply;
    endfunction

    function automatic void check_field(input string field, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, expected, actual);
            fail_count++;
        end
    endfunction

    // Compare each result transfer first, then predict from each request transfer.
    always @(posedge clk or negedge rst_n)
    begin
        slot_reply_t oldest;
        if (!rst_n)
        begin
            shadow_count = 0;
            shadow_capacity = CAPACITY_RESET;
            expected_replies.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("Result transfer with no outstanding request (status %0d)", status);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_replies.pop_front();
                    check_field("status", int'(oldest.status), int'(status));
                    check_field("entry_count", int'(oldest.entry_count), int'(entry_count));
                    check_field("read_hour", int'(oldest.read_hour), int'(read_hour));
                    check_field("read_minute", int'(oldest.read_minute), int'(read_minute));
                    checked_count++;
                end
            end
            if (in_valid && in_ready)
                expected_replies.push_back(predict_reply(op, slot_hour, slot_minute, entry_index));
            if (cfg_we)
                shadow_capacity = cfg_wdata;
        end
        pending_count = expected_replies.size();
    end

endmodule

// File: tb/sorted_time_slot_table_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for sorted_time_slot_table_unit: clock, reset, request and result stimulus.
// Depends on sts_pkg, the block itself and slot_table_checker.

module sorted_time_slot_table_unit_test;
    import sts_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 8;
    localparam int PHASE_ITEMS    = 210;
    localparam int HOLD_CYCLES    = 80;
    // The fourth operation code is unused by the block.
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [COUNT_W-1:0]  cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     req_op;
    logic [HOUR_W-1:0]   req_hour;
    logic [MINUTE_W-1:0] req_minute;
    logic [INDEX_W-1:0]  req_index;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] res_status;
    logic [COUNT_W-1:0]  res_count;
    logic [HOUR_W-1:0]   res_hour;
    logic [MINUTE_W-1:0] res_minute;
    int                  fail_count;
    int                  pending_count;
    int                  checked_count;

    int                  sender_idle_pct = 0;
    int                  receiver_idle_pct = 0;
    int                  hold_requests = 0;
    int                  requests_sent = 0;
    logic [KEY_W-1:0]    inserted_keys [$];

    sorted_time_slot_table_unit #(
        .MAX_ENTRIES (TABLE_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (req_op),
        .slot_hour   (req_hour),
        .slot_minute (req_minute),
        .entry_index (req_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (res_status),
        .entry_count (res_count),
        .read_hour   (res_hour),
        .read_minute (res_minute)
    );

    slot_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (req_op),
        .slot_hour     (req_hour),
        .slot_minute   (req_minute),
        .entry_index   (req_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (res_status),
        .entry_count   (res_count),
        .read_hour     (res_hour),
        .read_minute   (res_minute),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // Free-running 10 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random back-pressure, plus a long hold-off each time one is requested.
    initial
    begin
        int hold_left;
        int holds_seen;
        hold_left = 0;
        holds_seen = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_seen)
            begin
                hold_left = HOLD_CYCLES;
                holds_seen = hold_requests;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Offers one request, idling at random first, and returns at the accepting edge.
    task automatic send_request(
        input logic [OP_W-1:0]     o,
        input logic [HOUR_W-1:0]   h,
        input logic [MINUTE_W-1:0] m,
        input logic [INDEX_W-1:0]  ix
    );
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_op <= o;
        req_hour <= h;
        req_minute <= m;
        req_index <= ix;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    // Builds one random request; valid times often repeat stored keys to hit taken slots.
    task automatic send_random_request();
        int                  op_pick;
        int                  time_pick;
        logic [OP_W-1:0]     o;
        logic [HOUR_W-1:0]   h;
        logic [MINUTE_W-1:0] m;
        logic [KEY_W-1:0]    k;
        op_pick = $urandom_range(0, 99);
        time_pick = $urandom_range(0, 99);
        if (op_pick < 38)
            o = OP_INSERT;
        else if (op_pick < 68)
            o = OP_CHECK;
        else if (op_pick < 95)
            o = OP_READ;
        else
            o = OP_NOP;
        if (time_pick < 15)
        begin
            h = HOUR_W'($urandom_range(0, 31));
            m = MINUTE_W'($urandom_range(0, 63));
        end
        else if (time_pick < 45 && inserted_keys.size() > 0)
        begin
            k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            h = k[KEY_W-1:MINUTE_W];
            m = k[MINUTE_W-1:0];
        end
        else
        begin
            h = HOUR_W'($urandom_range(0, 23));
            m = MINUTE_W'($urandom_range(0, 59));
        end
        if (o == OP_INSERT && h < HOURS_PER_DAY && m < MINUTES_PER_HOUR)
            inserted_keys.push_back({h, m});
        send_request(o, h, m, INDEX_W'($urandom_range(0, 63)));
    endtask

    // Returns on a falling edge once every request has been answered.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_count != 0);
    endtask

    task automatic set_capacity(input logic [COUNT_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Closes the current burst and sets new traffic conditions while the block is idle.
    task automatic start_phase(input int send_pct, input int recv_pct, input logic [COUNT_W-1:0] cap);
        in_valid <= 1'b0;
        wait_drained();
        sender_idle_pct = send_pct;
        receiver_idle_pct = recv_pct;
        set_capacity(cap);
    endtask

    // Main sequence: reset, directed corner cases, then three random phases.
    initial
    begin
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        req_op <= OP_CHECK;
        req_hour <= '0;
        req_minute <= '0;
        req_index <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Small table: empty read, extremes, duplicates, bad times, filling up.
        sender_idle_pct = 30;
        receiver_idle_pct = 30;
        set_capacity(7'd4);
        send_request(OP_READ, 5'd0, 6'd0, 6'd0);
        send_request(OP_CHECK, 5'd0, 6'd0, 6'd0);
        send_request(OP_INSERT, 5'd23, 6'd59, 6'd63);
        send_request(OP_INSERT, 5'd0, 6'd0, 6'd0);
        send_request(OP_INSERT, 5'd23, 6'd59, 6'd0);
        send_request(OP_CHECK, 5'd23, 6'd59, 6'd0);
        send_request(OP_INSERT, 5'd24, 6'd0, 6'd0);
        send_request(OP_INSERT, 5'd12, 6'd60, 6'd0);
        send_request(OP_CHECK, 5'd31, 6'd63, 6'd63);
        send_request(OP_INSERT, 5'd12, 6'd30, 6'd0);
        send_request(OP_INSERT, 5'd1, 6'd1, 6'd0);
        send_request(OP_CHECK, 5'd5, 6'd5, 6'd0);
        send_request(OP_CHECK, 5'd31, 6'd63, 6'd0);
        send_request(OP_READ, 5'd31, 6'd63, 6'd0);
        send_request(OP_READ, 5'd0, 6'd0, 6'd3);
        send_request(OP_READ, 5'd0, 6'd0, 6'd4);
        send_request(OP_READ, 5'd0, 6'd0, 6'd63);
        send_request(OP_NOP, 5'd31, 6'd63, 6'd63);
        inserted_keys.push_back({5'd23, 6'd59});
        inserted_keys.push_back({5'd12, 6'd30});

        // Zero capacity, then capacity below the stored count, then the maximum.
        start_phase(30, 30, 7'd0);
        send_request(OP_CHECK, 5'd0, 6'd0, 6'd0);
        send_request(OP_INSERT, 5'd7, 6'd7, 6'd0);
        start_phase(30, 30, 7'd2);
        send_request(OP_INSERT, 5'd8, 6'd8, 6'd0);
        start_phase(0, 0, 7'd127);
        send_request(OP_INSERT, 5'd10, 6'd10, 6'd0);
        send_request(OP_READ, 5'd0, 6'd0, 6'd1);

        // Slow receiver, with one long hold-off so the block backs up into the sender.
        start_phase(19, 73, 7'd20);
        hold_requests++;
        repeat (PHASE_ITEMS) send_random_request();

        // Slow sender; capacity above the table size, so the table itself limits filling.
        start_phase(73, 19, 7'd127);
        repeat (PHASE_ITEMS) send_random_request();

        // Full speed on both sides with capacity equal to the table size.
        start_phase(0, 0, 7'd64);
        repeat (PHASE_ITEMS) send_random_request();

        in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d requests of every operation over capacities 0 to 127,",
                 requests_sent);
        $display("with %0d results compared field by field.", checked_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
